[hdl/fir51q15_pkg.sv]
package fir51q15_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int Q_SHIFT     = 15;
    localparam int TAPS_DEFAULT = 51;
    localparam int ROM_WORDS   = 51;
    localparam int ROM_IW      = $clog2(ROM_WORDS);
    // Wide enough to index any tap count up to 256
    localparam int ROM_IDX_W   = 8;

    localparam logic signed [SAMPLE_W-1:0] COEF_ROM [0:ROM_WORDS-1] = '{
        16'sd13,    -16'sd11,   -16'sd90,   -16'sd57,   16'sd169,   16'sd212,
        -16'sd186,  -16'sd416,  16'sd81,    16'sd525,   16'sd73,    -16'sd412,
        -16'sd46,   16'sd133,   -16'sd415,  -16'sd1,    16'sd1338,  16'sd438,
        -16'sd2369, -16'sd1655, 16'sd2894,  16'sd3387,  -16'sd2418, -16'sd4936,
        16'sd945,   16'sd5558,  16'sd945,   -16'sd4936, -16'sd2418, 16'sd3387,
        16'sd2894,  -16'sd1655, -16'sd2369, 16'sd438,   16'sd1338,  -16'sd1,
        -16'sd415,  16'sd133,   -16'sd46,   -16'sd412,  16'sd73,    16'sd525,
        16'sd81,    -16'sd416,  -16'sd186,  16'sd212,   16'sd169,   -16'sd57,
        -16'sd90,   -16'sd11,   16'sd13
    };

    // Control bundle from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    // Entries past the stored table read as zero
    function automatic logic signed [SAMPLE_W-1:0] coef_at(
        input logic [ROM_IDX_W-1:0] idx
    );
        logic signed [SAMPLE_W-1:0] c;
        c = '0;
        if (idx < ROM_IDX_W'(ROM_WORDS)) begin
            c = COEF_ROM[idx[ROM_IW-1:0]];
        end
        return c;
    endfunction

endpackage

[hdl/fir51q15_ram.sv]
module fir51q15_ram #(
    parameter int WIDTH = fir51q15_pkg::SAMPLE_W,
    parameter int DEPTH = fir51q15_pkg::TAPS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/fir51q15_mac.sv]
module fir51q15_mac #(
    parameter int ACC_W = 2 * fir51q15_pkg::SAMPLE_W + 7
) (
    input  logic                                       aclk,
    input  fir51q15_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [fir51q15_pkg::SAMPLE_W-1:0]   sample,
    input  logic signed [fir51q15_pkg::SAMPLE_W-1:0]   coef,
    output logic signed [ACC_W-1:0]                    acc
);

    localparam int SW = fir51q15_pkg::SAMPLE_W;

    logic signed [2*SW-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    // Register the product before it reaches the adder
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.acc_en) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= sample * coef;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[hdl/fir_filter_51_tap_q15.sv]
// A result reaches m_valid after the tap sweep and drain; the input stays closed
//   until the result is registered, so a new sample waits for the previous one; the single
//   shared multiply-accumulate unit handles one tap per cycle.
// A finished result waits in the output register while the next sample is taken.
// Reset (aresetn low, synchronous): delay line reads as all zeros, write
//   position returns to slot 0, no result pending; no clearing pass needed.
module fir_filter_51_tap_q15 #(
    parameter int TAPS = fir51q15_pkg::TAPS_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [fir51q15_pkg::SAMPLE_W-1:0] s_audio_sample,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [fir51q15_pkg::SAMPLE_W-1:0] m_filtered_sample
);

    localparam int SW    = fir51q15_pkg::SAMPLE_W;
    localparam int QS    = fir51q15_pkg::Q_SHIFT;
    localparam int RIW   = fir51q15_pkg::ROM_IDX_W;
    localparam int AW    = $clog2(TAPS);
    // Product width plus growth over TAPS terms, plus a guard bit
    localparam int ACC_W = 2 * SW + $clog2(TAPS) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]   wr_pos_reg, wr_pos_next;   // slot for the next sample
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;   // slot being read for tap k
    logic [AW-1:0]   k_reg, k_next;             // tap index
    logic [TAPS-1:0] valid_reg, valid_next;     // slot written since reset
    logic            issue_d1_reg;              // RAM data and coefficient ready
    logic            issue_d2_reg;              // product ready
    logic            tap_valid_reg;
    logic signed [SW-1:0] coef_reg;
    logic            m_valid_reg, m_valid_next;
    logic signed [SW-1:0] m_data_reg, m_data_next;

    logic                    accept;
    logic                    ram_we;
    logic [SW-1:0]           ram_rdata;
    logic signed [SW-1:0]    tap_sample;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    logic signed [SW-1:0]    sat_value;
    logic                    in_range;
    fir51q15_pkg::mac_ctrl_t mac_ctrl;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign ram_we  = accept;

    // Delay line storage: written on accept, read once per tap while running
    fir51q15_ram #(
        .WIDTH (SW),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_pos_reg),
        .wdata (s_audio_sample),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Slots never written since reset read as zero
    assign tap_sample = tap_valid_reg ? signed'(ram_rdata) : '0;

    assign mac_ctrl.clear  = accept;
    assign mac_ctrl.mul_en = issue_d1_reg;
    assign mac_ctrl.acc_en = issue_d2_reg;

    fir51q15_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .sample (tap_sample),
        .coef   (coef_reg),
        .acc    (acc)
    );

    // Q15 scaling, floor rounding, then saturate to 16 bits
    assign shifted  = acc >>> QS;
    assign in_range = (&shifted[ACC_W-1:SW-1]) || !(|shifted[ACC_W-1:SW-1]);
    assign sat_value = in_range ? shifted[SW-1:0]
                     : (shifted[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}}
                                         : {1'b0, {(SW-1){1'b1}}});

    always_comb begin
        state_next   = state_reg;
        wr_pos_next  = wr_pos_reg;
        rd_ptr_next  = rd_ptr_reg;
        k_next       = k_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // Drop the pending result once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    valid_next[wr_pos_reg] = 1'b1;
                    rd_ptr_next = wr_pos_reg;
                    k_next      = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                // Walk back in time: newest slot pairs with coefficient 0
                rd_ptr_next = (rd_ptr_reg == '0) ? AW'(TAPS - 1) : rd_ptr_reg - 1'b1;
                k_next      = k_reg + 1'b1;
                if (k_reg == AW'(TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // Wait for the last product to land, then for room at the output
                if (!issue_d1_reg && !issue_d2_reg && (!m_valid_reg || m_ready)) begin
                    m_valid_next = 1'b1;
                    m_data_next  = sat_value;
                    wr_pos_next  = (wr_pos_reg == AW'(TAPS - 1)) ? '0 : wr_pos_reg + 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wr_pos_reg    <= '0;
            rd_ptr_reg    <= '0;
            k_reg         <= '0;
            valid_reg     <= '0;
            issue_d1_reg  <= 1'b0;
            issue_d2_reg  <= 1'b0;
            tap_valid_reg <= 1'b0;
            coef_reg      <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            wr_pos_reg    <= wr_pos_next;
            rd_ptr_reg    <= rd_ptr_next;
            k_reg         <= k_next;
            valid_reg     <= valid_next;
            // Advance the tap pipeline alongside the registered RAM read
            issue_d1_reg  <= (state_reg == ST_RUN);
            issue_d2_reg  <= issue_d1_reg;
            tap_valid_reg <= valid_reg[rd_ptr_reg];
            coef_reg      <= fir51q15_pkg::coef_at(RIW'(k_reg));
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_filtered_sample = m_data_reg;

    // A taken sample keeps the input closed for the whole tap sweep
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready
    ) else $error("input accepted again right after a sample was taken");

    // A new result appears only out of the drain phase
    a_result_from_drain: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DRAIN)
    ) else $error("result raised outside the drain phase");

    // Pointers stay inside the delay line
    a_ptr_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        ({1'b0, wr_pos_reg} < (AW+1)'(TAPS)) && ({1'b0, rd_ptr_reg} < (AW+1)'(TAPS))
    ) else $error("delay line pointer out of range");

    // No accumulation may still be pending when the input reopens
    a_pipe_empty_idle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_ready |-> !issue_d1_reg && !issue_d2_reg
    ) else $error("tap pipeline busy while input is ready");

endmodule
